[rtl/frame_bitmap_allocator_assert.svh]
// Assertion macros used by the frame bitmap allocator checker.
`ifndef FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame bitmap allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame bitmap allocator assertion failed");

`endif

[rtl/fba_pkg.sv]
// Package with the constants, codes and types of the frame bitmap allocator.
package fba_pkg;

    localparam int MAX_FRAMES        = 32768;
    localparam int WORD_BITS         = 32;
    localparam int BIT_W             = $clog2(WORD_BITS);
    localparam int MAP_WORDS         = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW           = $clog2(MAP_WORDS);
    localparam int FRAME_W           = 15;
    localparam int FRAME_FIELD_LIMIT = 32768;
    localparam int SEARCH_MAX        = (MAX_FRAMES < FRAME_FIELD_LIMIT) ?
                                       MAX_FRAMES : FRAME_FIELD_LIMIT;
    localparam int COUNT_W           = 16;
    localparam int STATUS_W          = 3;
    localparam int ADDR_W            = 3;
    localparam int DATA_W            = 32;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(32768);

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ALLOCATED = 3'd0,
        STATUS_HAD_FRAME = 3'd1,
        STATUS_NO_MEMORY = 3'd2,
        STATUS_FREED     = 3'd3,
        STATUS_NOTHING   = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_FRAME_COUNT = 1'b0
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_WR,
        ST_DONE
    } state_t;

endpackage

[rtl/frame_bitmap_allocator.sv]
// First-fit physical frame allocator over a bitmap of used frames.
// After reset a clearing pass writes all 1024 bitmap words, one a cycle, before any
// transaction is taken; the frame count register resets to 32768.
// Allocate results come from a first-free scan that reads one bitmap word per cycle; free
// reads the bitmap word and then writes it back; other requests go straight to the result.
// One transaction at a time; a new request can be taken in the cycle its result appears.
module frame_bitmap_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fba_pkg::ADDR_W-1:0]          paddr,
    input  logic [fba_pkg::DATA_W-1:0]          pwdata,
    output logic [fba_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                operation,
    input  logic [fba_pkg::FRAME_W-1:0]         page_frame,
    input  logic                                kernel_page,
    input  logic                                writable_page,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [fba_pkg::STATUS_W-1:0]        status,
    output logic [fba_pkg::FRAME_W-1:0]         new_frame,
    output logic                                present_bit,
    output logic                                write_bit,
    output logic                                user_bit
);

    logic [fba_pkg::WORD_BITS-1:0] used_map [fba_pkg::MAP_WORDS];

    fba_pkg::state_t state_reg, state_next;

    logic [fba_pkg::WORD_AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [fba_pkg::COUNT_W-1:0]   frame_count_reg, frame_count_next;
    logic [fba_pkg::WORD_AW:0]     scan_addr_reg, scan_addr_next;
    logic [fba_pkg::WORD_AW-1:0]   chk_addr_reg, chk_addr_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    logic [fba_pkg::FRAME_W-1:0]   pf_reg, pf_next;
    logic                          wr_reg, wr_next;
    logic                          kern_reg, kern_next;
    logic [fba_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [fba_pkg::FRAME_W-1:0]   res_frame_reg, res_frame_next;
    logic                          res_present_reg, res_present_next;
    logic                          res_write_reg, res_write_next;
    logic                          res_user_reg, res_user_next;
    logic [fba_pkg::STATUS_W-1:0]  rsp_status_reg, rsp_status_next;
    logic [fba_pkg::FRAME_W-1:0]   rsp_frame_reg, rsp_frame_next;
    logic                          rsp_present_reg, rsp_present_next;
    logic                          rsp_write_reg, rsp_write_next;
    logic                          rsp_user_reg, rsp_user_next;

    logic [fba_pkg::WORD_BITS-1:0] rd_data_reg;

    logic                          mem_we;
    logic [fba_pkg::WORD_AW-1:0]   mem_waddr;
    logic [fba_pkg::WORD_BITS-1:0] mem_wdata;
    logic                          mem_re;
    logic [fba_pkg::WORD_AW-1:0]   mem_raddr;

    logic                          cfg_we;
    logic                          req_accept;
    logic                          slot_free;
    logic [fba_pkg::COUNT_W-1:0]   search_lim;
    logic [fba_pkg::COUNT_W-1:0]   chk_base;
    logic [fba_pkg::COUNT_W-1:0]   chk_room;
    logic [fba_pkg::WORD_BITS-1:0] bit_ok;
    logic [fba_pkg::WORD_BITS-1:0] cand;
    logic [fba_pkg::BIT_W-1:0]     found_idx;
    logic                          found;
    logic                          chk_last;
    logic                          scan_done;
    logic                          free_hits_map;

    assign pready     = 1'b1;
    assign cfg_we     = psel && penable && pwrite && (paddr[2] == fba_pkg::REG_FRAME_COUNT);
    assign prdata     = (paddr[2] == fba_pkg::REG_FRAME_COUNT) ?
                        fba_pkg::DATA_W'(frame_count_reg) : '0;

    assign req_stall  = (state_reg != fba_pkg::ST_IDLE);
    assign req_accept = req_valid && (state_reg == fba_pkg::ST_IDLE);
    assign slot_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign new_frame   = rsp_frame_reg;
    assign present_bit = rsp_present_reg;
    assign write_bit   = rsp_write_reg;
    assign user_bit    = rsp_user_reg;

    assign search_lim = (32'(frame_count_reg) > 32'(fba_pkg::SEARCH_MAX)) ?
                        fba_pkg::COUNT_W'(fba_pkg::SEARCH_MAX) : frame_count_reg;
    assign free_hits_map = 32'(page_frame) < 32'(fba_pkg::MAX_FRAMES);

    always_comb
    begin
        chk_base  = fba_pkg::COUNT_W'({chk_addr_reg, {fba_pkg::BIT_W{1'b0}}});
        chk_room  = search_lim - chk_base;
        for (int b = 0; b < fba_pkg::WORD_BITS; b++)
        begin
            bit_ok[b] = fba_pkg::COUNT_W'(b) < chk_room;
        end
        cand      = ~rd_data_reg & bit_ok;
        found_idx = '0;
        for (int b = fba_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                found_idx = fba_pkg::BIT_W'(b);
            end
        end
        found     = |cand;
        chk_last  = ((chk_base + fba_pkg::COUNT_W'(fba_pkg::WORD_BITS)) >= search_lim) ||
                    (chk_addr_reg == fba_pkg::WORD_AW'(fba_pkg::MAP_WORDS - 1));
        scan_done = found || chk_last;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == fba_pkg::WORD_AW'(fba_pkg::MAP_WORDS - 1))
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            fba_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (operation == fba_pkg::OP_ALLOC && page_frame == '0)
                    begin
                        state_next = fba_pkg::ST_SCAN;
                    end
                    else if (operation == fba_pkg::OP_FREE && page_frame != '0 &&
                             free_hits_map)
                    begin
                        state_next = fba_pkg::ST_FREE_WR;
                    end
                    else
                    begin
                        state_next = fba_pkg::ST_DONE;
                    end
                end
            end
            fba_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = fba_pkg::ST_DONE;
                end
            end
            fba_pkg::ST_FREE_WR:
            begin
                state_next = fba_pkg::ST_DONE;
            end
            fba_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fba_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next    = clr_addr_reg;
        frame_count_next = cfg_we ? pwdata[fba_pkg::COUNT_W-1:0] : frame_count_reg;
        scan_addr_next   = scan_addr_reg;
        chk_addr_next    = chk_addr_reg;
        pf_next          = pf_reg;
        wr_next          = wr_reg;
        kern_next        = kern_reg;
        res_status_next  = res_status_reg;
        res_frame_next   = res_frame_reg;
        res_present_next = res_present_reg;
        res_write_next   = res_write_reg;
        res_user_next    = res_user_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_status_next  = rsp_status_reg;
        rsp_frame_next   = rsp_frame_reg;
        rsp_present_next = rsp_present_reg;
        rsp_write_next   = rsp_write_reg;
        rsp_user_next    = rsp_user_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        unique case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            fba_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    pf_next          = page_frame;
                    wr_next          = writable_page;
                    kern_next        = kernel_page;
                    res_frame_next   = '0;
                    res_present_next = 1'b0;
                    res_write_next   = 1'b0;
                    res_user_next    = 1'b0;
                    if (operation == fba_pkg::OP_ALLOC)
                    begin
                        if (page_frame != '0)
                        begin
                            res_status_next = fba_pkg::STATUS_HAD_FRAME;
                            res_frame_next  = page_frame;
                        end
                        else
                        begin
                            mem_re         = 1'b1;
                            mem_raddr      = '0;
                            chk_addr_next  = '0;
                            scan_addr_next = (fba_pkg::WORD_AW + 1)'(1);
                        end
                    end
                    else
                    begin
                        if (page_frame != '0)
                        begin
                            res_status_next = fba_pkg::STATUS_FREED;
                            mem_re          = free_hits_map;
                            mem_raddr       = fba_pkg::WORD_AW'(page_frame >> fba_pkg::BIT_W);
                        end
                        else
                        begin
                            res_status_next = fba_pkg::STATUS_NOTHING;
                        end
                    end
                end
            end
            fba_pkg::ST_SCAN:
            begin
                if (scan_addr_reg < (fba_pkg::WORD_AW + 1)'(fba_pkg::MAP_WORDS))
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_addr_reg[fba_pkg::WORD_AW-1:0];
                    chk_addr_next  = scan_addr_reg[fba_pkg::WORD_AW-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                if (found)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = chk_addr_reg;
                    mem_wdata        = rd_data_reg |
                                       (fba_pkg::WORD_BITS'(1) << found_idx);
                    res_status_next  = fba_pkg::STATUS_ALLOCATED;
                    res_frame_next   = fba_pkg::FRAME_W'({chk_addr_reg, found_idx});
                    res_present_next = 1'b1;
                    res_write_next   = wr_reg;
                    res_user_next    = !kern_reg;
                end
                else if (chk_last)
                begin
                    res_status_next = fba_pkg::STATUS_NO_MEMORY;
                end
            end
            fba_pkg::ST_FREE_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = fba_pkg::WORD_AW'(pf_reg >> fba_pkg::BIT_W);
                mem_wdata = rd_data_reg &
                            ~(fba_pkg::WORD_BITS'(1) << pf_reg[fba_pkg::BIT_W-1:0]);
            end
            fba_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = res_status_reg;
                    rsp_frame_next   = res_frame_reg;
                    rsp_present_next = res_present_reg;
                    rsp_write_next   = res_write_reg;
                    rsp_user_next    = res_user_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            used_map[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= used_map[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fba_pkg::ST_CLEAR;
            clr_addr_reg    <= '0;
            frame_count_reg <= fba_pkg::FRAME_COUNT_RESET;
            scan_addr_reg   <= '0;
            chk_addr_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            frame_count_reg <= frame_count_next;
            scan_addr_reg   <= scan_addr_next;
            chk_addr_reg    <= chk_addr_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pf_reg          <= pf_next;
        wr_reg          <= wr_next;
        kern_reg        <= kern_next;
        res_status_reg  <= res_status_next;
        res_frame_reg   <= res_frame_next;
        res_present_reg <= res_present_next;
        res_write_reg   <= res_write_next;
        res_user_reg    <= res_user_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_frame_reg   <= rsp_frame_next;
        rsp_present_reg <= rsp_present_next;
        rsp_write_reg   <= rsp_write_next;
        rsp_user_reg    <= rsp_user_next;
    end

endmodule

[rtl/fba_checker.sv]
// Port checker for the frame bitmap allocator and its bind into the allocator module.
`include "frame_bitmap_allocator_assert.svh"

module fba_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_stall,
    input logic [fba_pkg::STATUS_W-1:0] status,
    input logic [fba_pkg::FRAME_W-1:0]  new_frame,
    input logic                         present_bit,
    input logic                         write_bit,
    input logic                         user_bit
);

    `FBA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)
    `FBA_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && rsp_stall, $stable(status) && $stable(new_frame))
    `FBA_ASSERT_IMPLY(a_alloc_present, clk, rst_n, rsp_valid && status == fba_pkg::STATUS_ALLOCATED, present_bit)
    `FBA_ASSERT_IMPLY(a_other_flags, clk, rst_n, rsp_valid && status != fba_pkg::STATUS_ALLOCATED, !present_bit && !write_bit && !user_bit)
    `FBA_ASSERT_IMPLY(a_zero_frame, clk, rst_n, rsp_valid && (status == fba_pkg::STATUS_FREED || status == fba_pkg::STATUS_NOTHING || status == fba_pkg::STATUS_NO_MEMORY), new_frame == '0)

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);
